// ===== rtl/core/glw_pkg.sv =====
// ----------------------------------------------------------------------------
// glw_pkg
// Shared constants, types and helpers for the grid line cell walker.
// ----------------------------------------------------------------------------
package glw_pkg;

  // Grid geometry and widths.
  localparam int GridSize = 32;
  localparam int CoordW   = 5;
  localparam int ErrW     = 8;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic signed [ErrW-1:0] err_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new request
    logic emit;        // write a cell into the output register
    logic sel_start;   // emitted cell is the current walk position
    logic corner;      // step the minor axis, subtract doubled major distance
    logic major_step;  // step the major axis, add doubled minor distance
    logic last;        // emitted cell closes the line
  } glw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_goal;         // walk position equals the goal cell
    logic err_nonneg;      // decision value is zero or positive
    logic major_hits_goal; // next major step lands on the goal coordinate
  } glw_sts_t;

  // Saturate a coordinate to the last grid cell.
  function automatic coord_t clamp_coord(input coord_t v);
    coord_t res;
    res = v;
    if (32'(v) > 32'(GridSize - 1)) begin
      res = CoordW'(GridSize - 1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/glw_if.sv =====
// ----------------------------------------------------------------------------
// glw_req_if / glw_cell_if
// Valid/ready channels for line requests and emitted line cells.
// ----------------------------------------------------------------------------
interface glw_req_if;
  logic                 valid;
  logic                 ready;
  logic [glw_pkg::CoordW-1:0] start_x;
  logic [glw_pkg::CoordW-1:0] start_z;
  logic [glw_pkg::CoordW-1:0] goal_x;
  logic [glw_pkg::CoordW-1:0] goal_z;

  modport source (output valid, start_x, start_z, goal_x, goal_z, input ready);
  modport sink   (input valid, start_x, start_z, goal_x, goal_z, output ready);
endinterface

interface glw_cell_if;
  logic                 valid;
  logic                 ready;
  logic [glw_pkg::CoordW-1:0] cell_x;
  logic [glw_pkg::CoordW-1:0] cell_z;
  logic                 last_cell;

  modport source (output valid, cell_x, cell_z, last_cell, input ready);
  modport sink   (input valid, cell_x, cell_z, last_cell, output ready);
endinterface

// ===== rtl/core/glw_datapath.sv =====
// ----------------------------------------------------------------------------
// glw_datapath
// Walk position, distances, decision value and the output cell register.
// ----------------------------------------------------------------------------
module glw_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  glw_pkg::coord_t   start_x_i,
  input  glw_pkg::coord_t   start_z_i,
  input  glw_pkg::coord_t   goal_x_i,
  input  glw_pkg::coord_t   goal_z_i,
  input  glw_pkg::glw_cmd_t cmd_i,
  output glw_pkg::glw_sts_t sts_o,
  output glw_pkg::coord_t   cell_x_o,
  output glw_pkg::coord_t   cell_z_o,
  output logic              last_cell_o
);
  import glw_pkg::*;

  coord_t x_q, z_q, gx_q, gz_q, dmaj_q, dmin_q;
  logic   negx_q, negz_q, zmaj_q;
  err_t   err_q;
  coord_t cell_x_q, cell_z_q;
  logic   last_q;

  // Request decode.
  coord_t            sx, sz, gx, gz, absx, absz, dmaj0, dmin0;
  logic [CoordW:0]   diffx, diffz;
  logic              zmaj0;
  err_t              err0;

  always_comb begin
    sx    = clamp_coord(start_x_i);
    sz    = clamp_coord(start_z_i);
    gx    = clamp_coord(goal_x_i);
    gz    = clamp_coord(goal_z_i);
    diffx = {1'b0, gx} - {1'b0, sx};
    diffz = {1'b0, gz} - {1'b0, sz};
    absx  = diffx[CoordW] ? CoordW'(-diffx) : diffx[CoordW-1:0];
    absz  = diffz[CoordW] ? CoordW'(-diffz) : diffz[CoordW-1:0];
    zmaj0 = absx < absz;
    dmaj0 = zmaj0 ? absz : absx;
    dmin0 = zmaj0 ? absx : absz;
    err0  = ErrW'({dmin0, 1'b0}) - ErrW'(dmaj0);
  end

  // One-cell advance in each axis toward the goal.
  coord_t x_adv, z_adv, cand_x, cand_z;
  err_t   err_corner, err_major;

  always_comb begin
    x_adv      = x_q + (negx_q ? {CoordW{1'b1}} : CoordW'(1));
    z_adv      = z_q + (negz_q ? {CoordW{1'b1}} : CoordW'(1));
    // Both corner and major cells are the major-advanced position.
    cand_x     = zmaj_q ? x_q : x_adv;
    cand_z     = zmaj_q ? z_adv : z_q;
    err_corner = err_q - ErrW'({dmaj_q, 1'b0});
    err_major  = err_q + ErrW'({dmin_q, 1'b0});
  end

  assign sts_o.at_goal         = (x_q == gx_q) && (z_q == gz_q);
  assign sts_o.err_nonneg      = ~err_q[ErrW-1];
  assign sts_o.major_hits_goal = zmaj_q ? (z_adv == gz_q) : (x_adv == gx_q);

  // Walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      z_q    <= '0;
      gx_q   <= '0;
      gz_q   <= '0;
      dmaj_q <= '0;
      dmin_q <= '0;
      negx_q <= 1'b0;
      negz_q <= 1'b0;
      zmaj_q <= 1'b0;
      err_q  <= '0;
    end else if (cmd_i.load) begin
      x_q    <= sx;
      z_q    <= sz;
      gx_q   <= gx;
      gz_q   <= gz;
      dmaj_q <= dmaj0;
      dmin_q <= dmin0;
      negx_q <= diffx[CoordW];
      negz_q <= diffz[CoordW];
      zmaj_q <= zmaj0;
      err_q  <= err0;
    end else if (cmd_i.corner) begin
      if (zmaj_q) begin
        x_q <= x_adv;
      end else begin
        z_q <= z_adv;
      end
      err_q <= err_corner;
    end else if (cmd_i.major_step) begin
      if (zmaj_q) begin
        z_q <= z_adv;
      end else begin
        x_q <= x_adv;
      end
      err_q <= err_major;
    end
  end

  // Output cell register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      cell_x_q <= cmd_i.sel_start ? x_q : cand_x;
      cell_z_q <= cmd_i.sel_start ? z_q : cand_z;
      last_q   <= cmd_i.last;
    end
  end

  assign cell_x_o    = cell_x_q;
  assign cell_z_o    = cell_z_q;
  assign last_cell_o = last_q;

endmodule

// ===== rtl/core/glw_ctrl.sv =====
// ----------------------------------------------------------------------------
// glw_ctrl
// Sequencer for one line walk: start cell, then corner and major steps.
// ----------------------------------------------------------------------------
module glw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  glw_pkg::glw_sts_t sts_i,
  output glw_pkg::glw_cmd_t cmd_o
);
  import glw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_MAJOR
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  glw_cmd_t cmd;

  assign out_free = ~out_valid_q | out_ready_i;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel_start = 1'b1;
          cmd.last      = sts_i.at_goal;
          state_d       = sts_i.at_goal ? S_IDLE : S_WALK;
        end
      end
      S_WALK: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (sts_i.err_nonneg) begin
            cmd.corner = 1'b1;
            state_d    = S_MAJOR;
          end else begin
            cmd.major_step = 1'b1;
            cmd.last       = sts_i.major_hits_goal;
            state_d        = sts_i.major_hits_goal ? S_IDLE : S_WALK;
          end
        end
      end
      S_MAJOR: begin
        if (out_free) begin
          cmd.emit       = 1'b1;
          cmd.major_step = 1'b1;
          cmd.last       = sts_i.major_hits_goal;
          state_d        = sts_i.major_hits_goal ? S_IDLE : S_WALK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A new cell fills the output slot; a taken cell empties it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // A waiting cell is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd.emit)
    else $error("glw_ctrl: output cell overwritten while stalled");

  // An accepted request always starts with the start cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == S_START))
    else $error("glw_ctrl: accepted request did not enter start state");

  // The closing cell returns the walker to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && cmd.last) |=> (state_q == S_IDLE && out_valid_q))
    else $error("glw_ctrl: last cell did not end the walk");

  // The major step state is only entered right after a corner cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAJOR && $past(state_q) != S_MAJOR) |-> $past(cmd.corner))
    else $error("glw_ctrl: major step without preceding corner");

endmodule

// ===== rtl/core/grid_line_cell_walker.sv =====
// Start: the request is loaded into the walk registers, then the start state writes
// the start cell into the output register once the output slot is free.
// Throughput: one cell per cycle while the output is taken; a line has 1 to 63 cells,
// and no new request is taken until the closing cell has been emitted.
// Reset: asynchronous, active low; the walker returns to idle with no cell pending.
// ----------------------------------------------------------------------------
// grid_line_cell_walker
// Emits the cells of a 4-connected Bresenham line from a start to a goal cell.
// ----------------------------------------------------------------------------
module grid_line_cell_walker (
  input  logic       clk_i,
  input  logic       rst_ni,
  glw_req_if.sink    req_i,
  glw_cell_if.source res_o
);
  import glw_pkg::*;

  glw_cmd_t cmd;
  glw_sts_t sts;

  // Control sequencer.
  glw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Walk datapath and output cell register.
  glw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_x_i   (req_i.start_x),
    .start_z_i   (req_i.start_z),
    .goal_x_i    (req_i.goal_x),
    .goal_z_i    (req_i.goal_z),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cell_x_o    (res_o.cell_x),
    .cell_z_o    (res_o.cell_z),
    .last_cell_o (res_o.last_cell)
  );

endmodule
